### rtl/gda_pkg.sv
// Shared types, constants and calendar helpers for the Gregorian date adder.
// Used by the interfaces, the sequencer, the arithmetic unit and the checker.
// No dependencies.
package gda_pkg;

	// Only the low DAY_COUNT_BITS bits of days_to_add take part.
	localparam int DAY_COUNT_BITS = 16;
	localparam int CNT_W = DAY_COUNT_BITS;
	// The shared adder must hold a day count plus an ordinal day (up to 366).
	localparam int ALU_W = ((CNT_W > 9) ? CNT_W : 9) + 1;

	localparam logic [3:0] MONTHS = 4'd12;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};
	localparam logic [8:0] COMMON_YEAR_DAYS = 9'd365;

	// A 14-bit year is a multiple of 25 exactly when its product with the
	// inverse of 25 modulo 2^14 does not exceed (2^14 - 1) / 25.
	localparam logic [13:0] INV25 = 14'd7209;
	localparam logic [13:0] DIV25_MAX = 14'd655;

	typedef logic [ALU_W-1:0] alu_word_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [15:0] days_to_add;
	} in_item_t;

	typedef struct packed {
		logic        valid_res;
		logic [4:0]  out_day;
		logic [3:0]  out_month;
		logic [13:0] out_year;
		logic [8:0]  day_of_year;
		logic        leap;
	} out_item_t;

	typedef struct packed {
		logic idle;
		logic done;
	} seq_stat_t;

	// Divisible by 4, except centuries that are not divisible by 400.
	function automatic logic is_leap(input logic [13:0] y);
		logic [13:0] scaled;
		scaled = y * INV25;
		if (y[1:0] != 2'b00) begin
			is_leap = 1'b0;
		end else if (scaled > DIV25_MAX) begin
			is_leap = 1'b1;
		end else begin
			is_leap = (y[3:0] == 4'd0);
		end
	endfunction

	// Length of month m; months outside 1 to 12 give 0.
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic lp);
		logic [3:0] idx;
		idx = m - 4'd1;
		if (m == 4'd0 || m > MONTHS) begin
			month_days = 5'd0;
		end else if (m == MONTH_FEB) begin
			month_days = MONTH_LEN[idx] + 5'(lp);
		end else begin
			month_days = MONTH_LEN[idx];
		end
	endfunction

	function automatic logic [8:0] year_days(input logic lp);
		year_days = COMMON_YEAR_DAYS + 9'(lp);
	endfunction

	function automatic logic [CNT_W-1:0] day_count(input logic [15:0] raw);
		logic [31:0] wide;
		wide = 32'(raw);
		day_count = wide[CNT_W-1:0];
	endfunction

endpackage

### rtl/gda_in_if.sv
// Request channel of the date adder: valid, ready and one start date.
// Depends on gda_pkg for the payload type.
interface gda_in_if;
	import gda_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### rtl/gda_out_if.sv
// Result channel of the date adder: valid, ready and one advanced date.
// Depends on gda_pkg for the payload type.
interface gda_out_if;
	import gda_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### rtl/gda_alu.sv
// Shared add and compare unit of the date adder: sum = a + b, dif = sum - c,
// over = (sum > c). Depends on gda_pkg for the word type.
module gda_alu (
	input  gda_pkg::alu_word_t a,
	input  gda_pkg::alu_word_t b,
	input  gda_pkg::alu_word_t c,
	output gda_pkg::alu_word_t sum,
	output gda_pkg::alu_word_t dif,
	output logic               over
);
	import gda_pkg::*;

	logic borrow;

	assign sum = a + b;
	assign {borrow, dif} = {1'b0, sum} - {1'b0, c};
	assign over = !borrow && (dif != '0);
endmodule

### rtl/gda_seq.sv
// Sequencer and working registers of the date adder; every step runs one
// operation through the shared gda_alu. Depends on gda_pkg and gda_alu.
module gda_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  gda_pkg::in_item_t   item,
	input  logic                take,
	output gda_pkg::seq_stat_t  stat,
	output gda_pkg::out_item_t  res
);
	import gda_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_ORD   = 3'd2;
	localparam logic [2:0] S_YEAR  = 3'd3;
	localparam logic [2:0] S_MON   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]       state_q;
	logic [8:0]       d_q;
	logic [3:0]       m_q;
	logic [13:0]      y_q;
	logic [CNT_W-1:0] r_q;
	logic [8:0]       doy_q;
	logic             lp_q;
	logic             ok_q;

	alu_word_t op_a, op_b, op_c, sum, dif;
	logic      over;
	logic      lp_now;
	logic      bad_date;
	logic [13:0] y_next;

	gda_alu u_alu (
		.a(op_a),
		.b(op_b),
		.c(op_c),
		.sum(sum),
		.dif(dif),
		.over(over)
	);

	assign lp_now = is_leap(y_q);
	assign y_next = y_q + 14'd1;
	assign bad_date = (d_q == 9'd0) || (m_q == 4'd0) || (m_q > MONTHS) || over;

	always_comb begin
		op_a = '0;
		op_b = '0;
		op_c = '0;
		case (state_q)
			S_CHECK: begin
				op_a = ALU_W'(d_q);
				op_c = ALU_W'(month_days(m_q, lp_now));
			end
			S_ORD: begin
				op_a = ALU_W'(doy_q);
				op_b = ALU_W'(month_days(m_q - 4'd1, lp_q));
			end
			S_YEAR: begin
				op_a = ALU_W'(r_q);
				op_b = ALU_W'(doy_q);
				op_c = ALU_W'(year_days(lp_q));
			end
			S_MON: begin
				op_a = ALU_W'(d_q);
				op_c = ALU_W'(month_days(m_q, lp_q));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= bad_date ? S_FIN : S_ORD;
				end
				S_ORD: begin
					if (m_q <= 4'd1) state_q <= S_YEAR;
				end
				S_YEAR: begin
					if (!over) state_q <= S_MON;
				end
				S_MON: begin
					if (m_q >= MONTHS || !over) state_q <= S_FIN;
				end
				S_FIN: begin
					if (take) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					d_q <= 9'(item.day);
					m_q <= item.month;
					y_q <= item.year;
					r_q <= day_count(item.days_to_add);
				end
			end
			S_CHECK: begin
				ok_q  <= !bad_date;
				lp_q  <= bad_date ? 1'b0 : lp_now;
				doy_q <= bad_date ? 9'd0 : d_q;
			end
			S_ORD: begin
				// Walk the month back to January, adding each earlier month.
				if (m_q > 4'd1) begin
					doy_q <= sum[8:0];
					m_q   <= m_q - 4'd1;
				end
			end
			S_YEAR: begin
				// Rolling over leaves ordinal day 0, which stands for the last
				// day of the year just left; the next pass adds from there.
				if (over) begin
					r_q   <= dif[CNT_W-1:0];
					doy_q <= 9'd0;
					y_q   <= y_next;
					lp_q  <= is_leap(y_next);
				end else begin
					doy_q <= sum[8:0];
					d_q   <= sum[8:0];
				end
			end
			S_MON: begin
				if (m_q < MONTHS && over) begin
					d_q <= dif[8:0];
					m_q <= m_q + 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_FIN);

	assign res.valid_res   = ok_q;
	assign res.out_day     = d_q[4:0];
	assign res.out_month   = m_q;
	assign res.out_year    = y_q;
	assign res.day_of_year = doy_q;
	assign res.leap        = lp_q;
endmodule

### rtl/gregorian_date_add_days.sv
// Top level of the Gregorian date adder: sequencer plus output register.
// Depends on gda_pkg, gda_in_if, gda_out_if, gda_alu and gda_seq.
//
//   Channel   Role    Payload
//   request   sink    day, month, year, days_to_add
//   result    source  valid_res, out_day, out_month, out_year, day_of_year, leap
//
// A valid date passes the check, the month walk back to January, the
// whole-year loop and the month walk forward before it loads the output
// register; a rejected date goes from the check to the final state. The
// whole-year loop runs through the shared adder, one year per cycle. A new
// request is taken in the cycle after the result moves to the output register,
// even while that result waits; a stalled output register holds the sequencer
// in its final state. Reset clears the sequencer and output valid.
module gregorian_date_add_days (
	input  logic clk,
	input  logic arst_n,
	gda_in_if.sink   request,
	gda_out_if.source result
);
	import gda_pkg::*;

	seq_stat_t stat;
	out_item_t seq_res;
	out_item_t out_q;
	logic      out_valid_q;
	logic      take;

	assign take = stat.done && (!out_valid_q || result.ready);

	gda_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(request.valid && stat.idle),
		.item(request.payload),
		.take(take),
		.stat(stat),
		.res(seq_res)
	);

	assign request.ready = stat.idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) out_q <= seq_res;
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;
endmodule

### rtl/gda_chk.sv
// Port-level checker for the Gregorian date adder, bound to the top level.
// Depends on gda_pkg for the result type.
module gda_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input gda_pkg::out_item_t out_item
);
	import gda_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed or dropped");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while the previous one is still at work");

	a_invalid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.valid_res |-> out_item.day_of_year == 9'd0 && !out_item.leap)
		else $error("rejected date carries an ordinal day or leap flag");

	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.valid_res |->
			out_item.out_day != 5'd0 && out_item.out_month != 4'd0 &&
			out_item.out_month <= MONTHS && out_item.day_of_year != 9'd0 &&
			(out_item.leap || out_item.day_of_year <= COMMON_YEAR_DAYS))
		else $error("advanced date out of range");
endmodule

bind gregorian_date_add_days gda_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(request.valid),
	.in_ready(request.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_item(result.payload)
);
